FILE: sv/v3a_pkg.sv
// ----------------------------------------------------------------------------
// v3a_pkg - shared types and constants of the vector alu
// opcodes, status codes, item structs, pipeline carry struct, saturation
// ----------------------------------------------------------------------------
package v3a_pkg;

  localparam int WORD_BITS   = 32;
  localparam int FRAC_BITS   = 16;
  localparam int PROD_W      = 2 * WORD_BITS + 2;       // 33 x 33 product
  localparam int SAT_W       = 2 * WORD_BITS + 4;       // wide sums before saturation
  localparam int SQ_W        = 2 * WORD_BITS;           // root operand
  localparam int SQRT_STAGES = WORD_BITS;               // one root bit per stage
  localparam int DIV_W       = WORD_BITS + FRAC_BITS;   // dividend and quotient width
  localparam int CFG_W       = 16;
  localparam int LANES       = 3;

  localparam logic [CFG_W-1:0]     MIN_LEN_RESET = 16'd7;
  localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef enum logic [3:0] {
    FN_ADD     = 4'd0,
    FN_SUB     = 4'd1,
    FN_ADDSCAL = 4'd2,
    FN_SUBSCAL = 4'd3,
    FN_MULSCAL = 4'd4,
    FN_DIVSCAL = 4'd5,
    FN_DOT     = 4'd6,
    FN_CROSS   = 4'd7,
    FN_LEN     = 4'd8,
    FN_NORM    = 4'd9,
    FN_DISTSQ  = 4'd10,
    FN_DIST    = 4'd11
  } func_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  typedef struct packed {
    logic [3:0]                  func;
    logic signed [WORD_BITS-1:0] a_x;
    logic signed [WORD_BITS-1:0] a_y;
    logic signed [WORD_BITS-1:0] a_z;
    logic signed [WORD_BITS-1:0] b_x;
    logic signed [WORD_BITS-1:0] b_y;
    logic signed [WORD_BITS-1:0] b_z;
    logic signed [WORD_BITS-1:0] scalar_in;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] r_x;
    logic signed [WORD_BITS-1:0] r_y;
    logic signed [WORD_BITS-1:0] r_z;
    logic signed [WORD_BITS-1:0] scalar_out;
    logic [1:0]                  status;
  } out_item_t;

  typedef struct packed {
    logic                 flag;
    logic [WORD_BITS-1:0] val;
  } sat_t;

  // what travels alongside the root and divider pipelines
  typedef struct packed {
    logic [3:0]                       func;
    logic [LANES-1:0][WORD_BITS-1:0]  a;
    logic [WORD_BITS-1:0]             s;
    logic [LANES-1:0][WORD_BITS-1:0]  r;
    logic [WORD_BITS-1:0]             so;
    logic                             flag;
    logic                             norm_short;
    logic [LANES-1:0]                 q_neg;
  } carry_t;

  // clamp a wide two's complement value to the word range
  function automatic sat_t sat_word(input logic [SAT_W-1:0] v);
    sat_t res;
    res.flag = (v[SAT_W-1:WORD_BITS-1] != {(SAT_W-WORD_BITS+1){v[SAT_W-1]}});
    if (res.flag) begin
      res.val = v[SAT_W-1] ? WORD_MIN : WORD_MAX;
    end else begin
      res.val = v[WORD_BITS-1:0];
    end
    return res;
  endfunction

endpackage

FILE: sv/v3a_lane.sv
// ----------------------------------------------------------------------------
// v3a_lane - one component lane
// operand select and multiply, then rounding and saturation of the
// per-component results (add, sub, scalar ops, cross)
// ----------------------------------------------------------------------------
module v3a_lane (
  input  logic                                  clk,
  input  logic [3:0]                            func_i,
  input  logic signed [v3a_pkg::WORD_BITS-1:0]  a_i,
  input  logic signed [v3a_pkg::WORD_BITS-1:0]  b_i,
  input  logic signed [v3a_pkg::WORD_BITS-1:0]  a_j,
  input  logic signed [v3a_pkg::WORD_BITS-1:0]  b_k,
  input  logic signed [v3a_pkg::WORD_BITS-1:0]  a_k,
  input  logic signed [v3a_pkg::WORD_BITS-1:0]  b_j,
  input  logic signed [v3a_pkg::WORD_BITS-1:0]  s_i,
  output logic signed [v3a_pkg::PROD_W-1:0]     p1_o,
  output v3a_pkg::sat_t                         res_o
);

  localparam int WB  = v3a_pkg::WORD_BITS;
  localparam int SW  = v3a_pkg::SAT_W;
  localparam logic [SW-1:0] HALF = SW'(1) << (v3a_pkg::FRAC_BITS - 1);

  logic signed [WB:0]         d;
  logic signed [WB:0]         x1;
  logic signed [WB:0]         y1;
  logic signed [WB:0]         o;
  logic signed [WB+1:0]       as_nxt;
  logic signed [v3a_pkg::PROD_W-1:0] p1_r;
  logic signed [2*WB-1:0]     p2_nxt;
  logic signed [2*WB-1:0]     p2_r;
  logic signed [WB+1:0]       as_r;
  logic [3:0]                 func_r;
  logic signed [SW-1:0]       ms_rnd;
  logic signed [SW-1:0]       cr_rnd;
  logic signed [SW-1:0]       ms;
  logic signed [SW-1:0]       cr;
  v3a_pkg::sat_t              res_nxt;
  v3a_pkg::sat_t              res_r;

  // stage 1: operand select
  always_comb begin
    d  = (WB+1)'(a_i) - (WB+1)'(b_i);
    x1 = (WB+1)'(a_i);
    y1 = (WB+1)'(s_i);
    case (func_i) inside
      v3a_pkg::FN_DOT: begin
        y1 = (WB+1)'(b_i);
      end
      v3a_pkg::FN_CROSS: begin
        x1 = (WB+1)'(a_j);
        y1 = (WB+1)'(b_k);
      end
      v3a_pkg::FN_LEN, v3a_pkg::FN_NORM: begin
        y1 = (WB+1)'(a_i);
      end
      v3a_pkg::FN_DISTSQ, v3a_pkg::FN_DIST: begin
        x1 = d;
        y1 = d;
      end
      default: begin
      end
    endcase
    o      = (func_i == v3a_pkg::FN_ADD || func_i == v3a_pkg::FN_SUB) ?
             (WB+1)'(b_i) : (WB+1)'(s_i);
    as_nxt = func_i[0] ? ((WB+2)'(a_i) - (WB+2)'(o)) : ((WB+2)'(a_i) + (WB+2)'(o));
    p2_nxt = a_k * b_j;
  end

  always_ff @(posedge clk) begin
    p1_r   <= x1 * y1;
    p2_r   <= p2_nxt;
    as_r   <= as_nxt;
    func_r <= func_i;
  end

  // stage 2: round half up and saturate
  always_comb begin
    ms_rnd = SW'(p1_r) + $signed(HALF);
    cr_rnd = SW'(p1_r) - SW'(p2_r) + $signed(HALF);
    ms     = ms_rnd >>> v3a_pkg::FRAC_BITS;
    cr     = cr_rnd >>> v3a_pkg::FRAC_BITS;
    res_nxt = '0;
    case (func_r) inside
      v3a_pkg::FN_ADD, v3a_pkg::FN_SUB, v3a_pkg::FN_ADDSCAL, v3a_pkg::FN_SUBSCAL: begin
        res_nxt = v3a_pkg::sat_word(SW'(as_r));
      end
      v3a_pkg::FN_MULSCAL: begin
        res_nxt = v3a_pkg::sat_word(ms);
      end
      v3a_pkg::FN_CROSS: begin
        res_nxt = v3a_pkg::sat_word(cr);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign p1_o  = p1_r;
  assign res_o = res_r;

endmodule

FILE: sv/v3a_isqrt.sv
// ----------------------------------------------------------------------------
// v3a_isqrt - pipelined integer square root
// floor of the root of a 64-bit value, one result bit per stage
// ----------------------------------------------------------------------------
module v3a_isqrt (
  input  logic                             clk,
  input  logic [v3a_pkg::SQ_W-1:0]         x_i,
  output logic [v3a_pkg::WORD_BITS-1:0]    root_o
);

  localparam int N  = v3a_pkg::SQRT_STAGES;
  localparam int XW = v3a_pkg::SQ_W;

  logic [XW-1:0] xs   [N];
  logic [XW-1:0] rs   [N];
  logic [XW-1:0] x_r  [N];
  logic [XW-1:0] r_r  [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [XW-1:0] BIT = XW'(1) << (XW - 2 - 2 * k);
    logic [XW-1:0] trial;

    if (k == 0) begin : g_first
      assign xs[k] = x_i;
      assign rs[k] = '0;
    end else begin : g_next
      assign xs[k] = x_r[k-1];
      assign rs[k] = r_r[k-1];
    end

    assign trial = rs[k] + BIT;

    always_ff @(posedge clk) begin
      if (xs[k] >= trial) begin
        x_r[k] <= xs[k] - trial;
        r_r[k] <= (rs[k] >> 1) + BIT;
      end else begin
        x_r[k] <= xs[k];
        r_r[k] <= rs[k] >> 1;
      end
    end
  end

  assign root_o = r_r[N-1][v3a_pkg::WORD_BITS-1:0];

endmodule

FILE: sv/v3a_div.sv
// ----------------------------------------------------------------------------
// v3a_div - pipelined unsigned restoring divider
// 48-bit dividend over 32-bit divisor, one quotient bit per stage
// ----------------------------------------------------------------------------
module v3a_div (
  input  logic                              clk,
  input  logic [v3a_pkg::DIV_W-1:0]         num_i,
  input  logic [v3a_pkg::WORD_BITS-1:0]     den_i,
  output logic [v3a_pkg::DIV_W-1:0]         q_o
);

  localparam int N  = v3a_pkg::DIV_W;
  localparam int WB = v3a_pkg::WORD_BITS;

  logic [WB-1:0] rin   [N];
  logic [N-1:0]  win   [N];
  logic [WB-1:0] din   [N];
  logic [WB-1:0] rem_r [N];
  logic [N-1:0]  w_r   [N];
  logic [WB-1:0] den_r [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [WB:0] rt;
    logic [WB:0] diff;
    logic        ge;

    if (k == 0) begin : g_first
      assign rin[k] = '0;
      assign win[k] = num_i;
      assign din[k] = den_i;
    end else begin : g_next
      assign rin[k] = rem_r[k-1];
      assign win[k] = w_r[k-1];
      assign din[k] = den_r[k-1];
    end

    assign rt   = {rin[k], win[k][N-1]};
    assign diff = rt - {1'b0, din[k]};
    assign ge   = (rt >= {1'b0, din[k]});

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? diff[WB-1:0] : rt[WB-1:0];
      w_r[k]   <= {win[k][N-2:0], ge};
      den_r[k] <= din[k];
    end
  end

  assign q_o = w_r[N-1];

endmodule

FILE: sv/vec3_fixed_point_alu_top.sv
// ----------------------------------------------------------------------------
// vec3_fixed_point_alu_top - three-component Q16.16 vector alu
// add, sub, scalar ops, dot, cross, length, normalize and distances
// ----------------------------------------------------------------------------
// Fully pipelined: a new item may be started in every cycle and busy is
// never raised. Every item gives one result, marked by out_strobe for one
// cycle; the receiver cannot stall, so results must be taken as they appear.
// The latency is set by the
// 32-stage square root pipeline and the 48-stage divider lanes, which every
// item passes through whatever its opcode. The normalize threshold in
// cfg_wdata is written at any edge with cfg_we high and should only change
// while no item is in flight.
// ----------------------------------------------------------------------------
module vec3_fixed_point_alu_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  v3a_pkg::in_item_t                 in_data,
  output logic                              out_strobe,
  output v3a_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [v3a_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int WB  = v3a_pkg::WORD_BITS;
  localparam int SW  = v3a_pkg::SAT_W;
  localparam int NL  = v3a_pkg::LANES;
  localparam int NS  = v3a_pkg::SQRT_STAGES;
  localparam int ND  = v3a_pkg::DIV_W;
  // input, lane multiply, lane round / merge, root, prep, divider, output
  localparam int LAT = 3 + NS + 1 + ND + 1;
  localparam logic [SW-1:0] HALF = SW'(1) << (v3a_pkg::FRAC_BITS - 1);

  // config and valid tracking
  logic [v3a_pkg::CFG_W-1:0] min_len_r;
  logic [LAT-1:0]            vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= v3a_pkg::MIN_LEN_RESET;
      vld_r     <= '0;
    end else begin
      if (cfg_we) begin
        min_len_r <= cfg_wdata;
      end
      vld_r <= {vld_r[LAT-2:0], start};
    end
  end

  // never stalls
  assign busy = 1'b0;

  // stage 0: input register
  v3a_pkg::in_item_t in_r;

  always_ff @(posedge clk) begin
    in_r <= in_data;
  end

  logic signed [WB-1:0] av [NL];
  logic signed [WB-1:0] bv [NL];

  assign av[0] = in_r.a_x;
  assign av[1] = in_r.a_y;
  assign av[2] = in_r.a_z;
  assign bv[0] = in_r.b_x;
  assign bv[1] = in_r.b_y;
  assign bv[2] = in_r.b_z;

  // stages 1 and 2: component lanes
  logic signed [v3a_pkg::PROD_W-1:0] lane_p1  [NL];
  v3a_pkg::sat_t                     lane_res [NL];

  for (genvar i = 0; i < NL; i++) begin : g_lane
    localparam int J = (i + 1) % NL;
    localparam int K = (i + 2) % NL;

    v3a_lane u_lane (
      .clk    (clk),
      .func_i (in_r.func),
      .a_i    (av[i]),
      .b_i    (bv[i]),
      .a_j    (av[J]),
      .b_k    (bv[K]),
      .a_k    (av[K]),
      .b_j    (bv[J]),
      .s_i    (in_r.scalar_in),
      .p1_o   (lane_p1[i]),
      .res_o  (lane_res[i])
    );
  end

  // side copy of opcode and operands next to the lanes
  logic [3:0]             func1_r;
  logic [NL-1:0][WB-1:0]  a1_r;
  logic [WB-1:0]          s1_r;

  always_ff @(posedge clk) begin
    func1_r <= in_r.func;
    a1_r    <= {in_r.a_z, in_r.a_y, in_r.a_x};
    s1_r    <= in_r.scalar_in;
  end

  // stage 2: merge the lane products (dot, sum of squares)
  logic signed [SW-1:0]   sum_all;
  logic signed [SW-1:0]   sum_rnd;
  logic signed [SW-1:0]   sum_sh;
  v3a_pkg::sat_t          sum_sat;
  logic [v3a_pkg::SQ_W-1:0] sqin_nxt;
  logic [WB-1:0]          so2_nxt;
  logic                   flag2_nxt;

  always_comb begin
    sum_all = SW'(lane_p1[0]) + SW'(lane_p1[1]) + SW'(lane_p1[2]);
    sum_rnd = sum_all + $signed(HALF);
    sum_sh  = sum_rnd >>> v3a_pkg::FRAC_BITS;
    sum_sat = v3a_pkg::sat_word(sum_sh);
    // sums of squares at or above 2^64 clamp to all ones
    if (|sum_all[SW-1:v3a_pkg::SQ_W]) begin
      sqin_nxt = '1;
    end else begin
      sqin_nxt = sum_all[v3a_pkg::SQ_W-1:0];
    end
    so2_nxt   = '0;
    flag2_nxt = 1'b0;
    if (func1_r == v3a_pkg::FN_DOT || func1_r == v3a_pkg::FN_DISTSQ) begin
      so2_nxt   = sum_sat.val;
      flag2_nxt = sum_sat.flag;
    end
  end

  logic [3:0]               func2_r;
  logic [NL-1:0][WB-1:0]    a2_r;
  logic [WB-1:0]            s2_r;
  logic [WB-1:0]            so2_r;
  logic                     flag2_r;
  logic [v3a_pkg::SQ_W-1:0] sqin_r;

  always_ff @(posedge clk) begin
    func2_r <= func1_r;
    a2_r    <= a1_r;
    s2_r    <= s1_r;
    so2_r   <= so2_nxt;
    flag2_r <= flag2_nxt;
    sqin_r  <= sqin_nxt;
  end

  v3a_pkg::carry_t c2;

  always_comb begin
    c2            = '0;
    c2.func       = func2_r;
    c2.a          = a2_r;
    c2.s          = s2_r;
    c2.so         = so2_r;
    c2.flag       = flag2_r | lane_res[0].flag | lane_res[1].flag | lane_res[2].flag;
    c2.r          = {lane_res[2].val, lane_res[1].val, lane_res[0].val};
  end

  // root pipeline with carry delay line beside it
  logic [WB-1:0]   root;
  v3a_pkg::carry_t cdly_a_r [NS];

  v3a_isqrt u_isqrt (
    .clk    (clk),
    .x_i    (sqin_r),
    .root_o (root)
  );

  always_ff @(posedge clk) begin
    cdly_a_r[0] <= c2;
    for (int k = 1; k < NS; k++) begin
      cdly_a_r[k] <= cdly_a_r[k-1];
    end
  end

  // prep stage: length result, normalize threshold, divider operands
  v3a_pkg::carry_t cs;
  v3a_pkg::carry_t cp_nxt;
  logic [WB-1:0]   mag_a [NL];
  logic [WB-1:0]   mag_s;
  logic            is_divs;
  logic [ND-1:0]   num_nxt [NL];
  logic [WB-1:0]   den_nxt;

  always_comb begin
    cs      = cdly_a_r[NS-1];
    cp_nxt  = cs;
    is_divs = (cs.func == v3a_pkg::FN_DIVSCAL);
    mag_s   = cs.s[WB-1] ? (WB'(0) - cs.s) : cs.s;
    den_nxt = is_divs ? mag_s : root;
    for (int i = 0; i < NL; i++) begin
      mag_a[i]        = cs.a[i][WB-1] ? (WB'(0) - cs.a[i]) : cs.a[i];
      num_nxt[i]      = {mag_a[i], {v3a_pkg::FRAC_BITS{1'b0}}};
      cp_nxt.q_neg[i] = cs.a[i][WB-1] ^ (is_divs & cs.s[WB-1]);
    end
    cp_nxt.norm_short = (root == '0) || (root < WB'(min_len_r));
    if (cs.func == v3a_pkg::FN_LEN || cs.func == v3a_pkg::FN_DIST) begin
      // the root is unsigned, so its top bit means overflow of the word
      cp_nxt.so   = root[WB-1] ? v3a_pkg::WORD_MAX : root;
      cp_nxt.flag = root[WB-1];
    end
  end

  v3a_pkg::carry_t cp_r;
  logic [ND-1:0]   num_r [NL];
  logic [WB-1:0]   den_r;

  always_ff @(posedge clk) begin
    cp_r  <= cp_nxt;
    den_r <= den_nxt;
    for (int i = 0; i < NL; i++) begin
      num_r[i] <= num_nxt[i];
    end
  end

  // divider lanes with carry delay line beside them
  logic [ND-1:0]   quo [NL];
  v3a_pkg::carry_t cdly_b_r [ND];

  for (genvar i = 0; i < NL; i++) begin : g_div
    v3a_div u_div (
      .clk   (clk),
      .num_i (num_r[i]),
      .den_i (den_r),
      .q_o   (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    cdly_b_r[0] <= cp_r;
    for (int k = 1; k < ND; k++) begin
      cdly_b_r[k] <= cdly_b_r[k-1];
    end
  end

  // output stage: quotient signing and saturation, special cases, status
  v3a_pkg::carry_t    cd;
  v3a_pkg::out_item_t out_nxt;
  logic [NL-1:0][WB-1:0] rv;
  logic [WB-1:0]      qv   [NL];
  logic               qsat [NL];
  logic               use_q;
  logic               div_zero;
  logic               any_sat;

  always_comb begin
    cd       = cdly_b_r[ND-1];
    div_zero = (cd.func == v3a_pkg::FN_DIVSCAL) && (cd.s == '0);
    use_q    = (cd.func == v3a_pkg::FN_DIVSCAL && !div_zero) ||
               (cd.func == v3a_pkg::FN_NORM && !cd.norm_short);
    any_sat  = cd.flag;
    rv       = cd.r;
    for (int i = 0; i < NL; i++) begin
      if (cd.q_neg[i]) begin
        qsat[i] = (quo[i] > ND'(v3a_pkg::WORD_MIN));
        qv[i]   = qsat[i] ? v3a_pkg::WORD_MIN : (WB'(0) - quo[i][WB-1:0]);
      end else begin
        qsat[i] = (quo[i] > ND'(v3a_pkg::WORD_MAX));
        qv[i]   = qsat[i] ? v3a_pkg::WORD_MAX : quo[i][WB-1:0];
      end
      if (div_zero) begin
        // divide by zero: sign of the numerator picks the rail
        if (cd.a[i] == '0) begin
          rv[i] = '0;
        end else begin
          rv[i] = cd.a[i][WB-1] ? v3a_pkg::WORD_MIN : v3a_pkg::WORD_MAX;
        end
      end else if (use_q) begin
        rv[i]   = qv[i];
        any_sat = any_sat | qsat[i];
      end else if (cd.func == v3a_pkg::FN_NORM) begin
        // short vector passes through unchanged
        rv[i] = cd.a[i];
      end
    end
    out_nxt.r_x        = rv[0];
    out_nxt.r_y        = rv[1];
    out_nxt.r_z        = rv[2];
    out_nxt.scalar_out = cd.so;
    if (div_zero) begin
      out_nxt.status = v3a_pkg::ST_DIVZ;
    end else if (any_sat) begin
      out_nxt.status = v3a_pkg::ST_SAT;
    end else begin
      out_nxt.status = v3a_pkg::ST_OK;
    end
  end

  v3a_pkg::out_item_t out_r;

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_data   = out_r;
  assign out_strobe = vld_r[LAT-1];

endmodule

FILE: verif/v3a_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// v3a_checker - result checker for the three-component vector alu
// predicts each accepted item from its own Q16.16 model and compares every
// strobed result field by field, in order
// ----------------------------------------------------------------------------
module v3a_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  v3a_pkg::in_item_t           in_data,
  input  logic                        out_strobe,
  input  v3a_pkg::out_item_t          out_data,
  input  logic                        cfg_we,
  input  logic [15:0]                 cfg_wdata,
  output int                          fail_count,
  output int                          pending
);

  typedef logic signed [127:0] wide_t;

  logic [15:0]        min_length;
  v3a_pkg::out_item_t expected_results[$];

  function automatic logic [31:0] clamp(input wide_t v, inout logic flag);
    if (v > 128'sh7FFFFFFF) begin
      flag = 1'b1;
      return 32'h7FFFFFFF;
    end
    if (v < -128'sh80000000) begin
      flag = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  // floor of the square root, operand below 2^64
  function automatic wide_t root_floor(input wide_t x);
    wide_t r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (wide_t'(1) <<< b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // exact product sum rounded half up to 16 fraction bits
  function automatic wide_t round_q(input wide_t v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic wide_t elem(input logic [3:0] fn, input wide_t av, input wide_t bv,
                                 input wide_t sv);
    case (fn)
      v3a_pkg::FN_ADD:     return av + bv;
      v3a_pkg::FN_SUB:     return av - bv;
      v3a_pkg::FN_ADDSCAL: return av + sv;
      default:             return av - sv;
    endcase
  endfunction

  function automatic v3a_pkg::out_item_t vector_result(input v3a_pkg::in_item_t it,
                                                       input logic [15:0] min_len);
    v3a_pkg::out_item_t res;
    wide_t a[3], b[3], s, acc, len, d;
    logic flag;
    res  = '0;
    flag = 1'b0;
    a[0] = $signed(it.a_x); a[1] = $signed(it.a_y); a[2] = $signed(it.a_z);
    b[0] = $signed(it.b_x); b[1] = $signed(it.b_y); b[2] = $signed(it.b_z);
    s    = $signed(it.scalar_in);
    acc  = 0;
    case (it.func)
      v3a_pkg::FN_ADD, v3a_pkg::FN_SUB, v3a_pkg::FN_ADDSCAL, v3a_pkg::FN_SUBSCAL: begin
        res.r_x = clamp(elem(it.func, a[0], b[0], s), flag);
        res.r_y = clamp(elem(it.func, a[1], b[1], s), flag);
        res.r_z = clamp(elem(it.func, a[2], b[2], s), flag);
      end
      v3a_pkg::FN_MULSCAL: begin
        res.r_x = clamp(round_q(a[0] * s), flag);
        res.r_y = clamp(round_q(a[1] * s), flag);
        res.r_z = clamp(round_q(a[2] * s), flag);
      end
      v3a_pkg::FN_DIVSCAL: begin
        if (s == 0) begin
          // divide by zero: sign of each component picks the rail
          res.r_x = a[0] > 0 ? v3a_pkg::WORD_MAX : (a[0] < 0 ? v3a_pkg::WORD_MIN : '0);
          res.r_y = a[1] > 0 ? v3a_pkg::WORD_MAX : (a[1] < 0 ? v3a_pkg::WORD_MIN : '0);
          res.r_z = a[2] > 0 ? v3a_pkg::WORD_MAX : (a[2] < 0 ? v3a_pkg::WORD_MIN : '0);
        end else begin
          res.r_x = clamp((a[0] <<< 16) / s, flag);
          res.r_y = clamp((a[1] <<< 16) / s, flag);
          res.r_z = clamp((a[2] <<< 16) / s, flag);
        end
      end
      v3a_pkg::FN_DOT:
        res.scalar_out = clamp(round_q(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]), flag);
      v3a_pkg::FN_CROSS: begin
        res.r_x = clamp(round_q(a[1] * b[2] - a[2] * b[1]), flag);
        res.r_y = clamp(round_q(a[2] * b[0] - a[0] * b[2]), flag);
        res.r_z = clamp(round_q(a[0] * b[1] - a[1] * b[0]), flag);
      end
      v3a_pkg::FN_LEN, v3a_pkg::FN_NORM: begin
        acc = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        len = root_floor(acc);
        if (it.func == v3a_pkg::FN_LEN) begin
          res.scalar_out = clamp(len, flag);
        end else if (len == 0 || len < min_len) begin
          // short vector passes through
          res.r_x = a[0][31:0];
          res.r_y = a[1][31:0];
          res.r_z = a[2][31:0];
        end else begin
          res.r_x = clamp((a[0] <<< 16) / len, flag);
          res.r_y = clamp((a[1] <<< 16) / len, flag);
          res.r_z = clamp((a[2] <<< 16) / len, flag);
        end
      end
      v3a_pkg::FN_DISTSQ, v3a_pkg::FN_DIST: begin
        for (int i = 0; i < 3; i++) begin
          d   = a[i] - b[i];
          acc = acc + d * d;
        end
        if (it.func == v3a_pkg::FN_DISTSQ) begin
          res.scalar_out = clamp(round_q(acc), flag);
        end else begin
          // accumulator clips at 64 bits unsigned
          if (acc > 128'shFFFFFFFFFFFFFFFF) acc = 128'shFFFFFFFFFFFFFFFF;
          res.scalar_out = clamp(root_floor(acc), flag);
        end
      end
      default: ;
    endcase
    if (it.func == v3a_pkg::FN_DIVSCAL && s == 0) res.status = v3a_pkg::ST_DIVZ;
    else if (flag)                                res.status = v3a_pkg::ST_SAT;
    else                                          res.status = v3a_pkg::ST_OK;
    return res;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    v3a_pkg::out_item_t exp_item;
    if (!rst_n) begin
      min_length <= v3a_pkg::MIN_LEN_RESET;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) min_length <= cfg_wdata;
      if (start && !busy) expected_results.push_back(vector_result(in_data, min_length));
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          $error("result with no item waiting");
          fail_count <= fail_count + 1;
        end else begin
          exp_item = expected_results.pop_front();
          if (out_data.r_x !== exp_item.r_x)
            $error("r_x expected %h actual %h", exp_item.r_x, out_data.r_x);
          if (out_data.r_y !== exp_item.r_y)
            $error("r_y expected %h actual %h", exp_item.r_y, out_data.r_y);
          if (out_data.r_z !== exp_item.r_z)
            $error("r_z expected %h actual %h", exp_item.r_z, out_data.r_z);
          if (out_data.scalar_out !== exp_item.scalar_out)
            $error("scalar_out expected %h actual %h", exp_item.scalar_out,
                   out_data.scalar_out);
          if (out_data.status !== exp_item.status)
            $error("status expected %0d actual %0d", exp_item.status, out_data.status);
          if (out_data !== exp_item) fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench of the three-component vector alu
// directed corner items, then random items in phases of differing sender
// idling and normalize thresholds; a checker beside the block scores results
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LATENCY   = 85;
  localparam int WDOG_MAX  = 2000;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  v3a_pkg::in_item_t           in_data;
  logic                        out_strobe;
  v3a_pkg::out_item_t          out_data;
  logic                        cfg_we;
  logic [v3a_pkg::CFG_W-1:0]   cfg_wdata;
  int                          fail_count;
  int                          pending;
  int                          idle_pct;
  int                          quiet_cycles;

  vec3_fixed_point_alu_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  v3a_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog: cycles in which neither an item nor a result moves
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_MAX) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // operand mix: full random, mid-size, tiny (norm threshold) and rails
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2:    return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      3:    return 32'($signed($urandom_range(0, 64)) - 32);
      4: begin
        case ($urandom_range(0, 3))
          0: return v3a_pkg::WORD_MAX;
          1: return v3a_pkg::WORD_MIN;
          2: return 32'hFFFFFFFF;
          default: return 32'h00010000;
        endcase
      end
      default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    endcase
  endfunction

  function automatic v3a_pkg::in_item_t random_item();
    v3a_pkg::in_item_t it;
    it.func      = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                                : 4'($urandom_range(0, 11));
    it.a_x       = pick_word();
    it.a_y       = pick_word();
    it.a_z       = pick_word();
    it.b_x       = pick_word();
    it.b_y       = pick_word();
    it.b_z       = pick_word();
    it.scalar_in = ($urandom_range(0, 9) == 0) ? '0 : pick_word();
    return it;
  endfunction

  // each cycle the sender idles with probability idle_pct
  task automatic send_item(input v3a_pkg::in_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // threshold changes only once the pipeline has drained
  task automatic write_min_length(input logic [v3a_pkg::CFG_W-1:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic directed(input logic [3:0] fn, input logic [31:0] ax, input logic [31:0] ay,
                          input logic [31:0] az, input logic [31:0] bx,
                          input logic [31:0] by, input logic [31:0] bz,
                          input logic [31:0] sc);
    v3a_pkg::in_item_t it;
    it = {fn, ax, ay, az, bx, by, bz, sc};
    send_item(it);
  endtask

  initial begin
    int phase_pct[4];
    logic [v3a_pkg::CFG_W-1:0] thresholds[4];
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    idle_pct  = 0;
    phase_pct = '{0, 57, 0, 21};
    thresholds = '{16'd0, 16'hFFFF, 16'($urandom), v3a_pkg::MIN_LEN_RESET};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners under the reset threshold
    directed(v3a_pkg::FN_ADD, v3a_pkg::WORD_MAX, v3a_pkg::WORD_MIN, 1, 1, 32'hFFFFFFFF, 2, 0);
    directed(v3a_pkg::FN_SUB, v3a_pkg::WORD_MIN, v3a_pkg::WORD_MAX, 5, 1, 32'hFFFFFFFF, 7, 0);
    directed(v3a_pkg::FN_ADDSCAL, v3a_pkg::WORD_MAX, 0, v3a_pkg::WORD_MIN, 0, 0, 0,
             32'hFFFFFFFF);
    directed(v3a_pkg::FN_SUBSCAL, v3a_pkg::WORD_MIN, 3, v3a_pkg::WORD_MAX, 0, 0, 0,
             v3a_pkg::WORD_MIN);
    directed(v3a_pkg::FN_MULSCAL, v3a_pkg::WORD_MAX, v3a_pkg::WORD_MIN, 32'h00018000, 0, 0, 0,
             v3a_pkg::WORD_MAX);
    directed(v3a_pkg::FN_MULSCAL, 32'h00008000, 32'hFFFF8000, 3, 0, 0, 0, 32'h00010000);
    directed(v3a_pkg::FN_DIVSCAL, 32'h00050000, 32'hFFFB0000, 0, 0, 0, 0, 0);
    directed(v3a_pkg::FN_DIVSCAL, v3a_pkg::WORD_MAX, v3a_pkg::WORD_MIN, 7, 0, 0, 0, 1);
    directed(v3a_pkg::FN_DIVSCAL, v3a_pkg::WORD_MIN, 32'h00030000, 32'hFFFFFFF9, 0, 0, 0,
             32'hFFFFFFFF);
    directed(v3a_pkg::FN_DOT, v3a_pkg::WORD_MAX, v3a_pkg::WORD_MAX, v3a_pkg::WORD_MAX,
             v3a_pkg::WORD_MAX, v3a_pkg::WORD_MAX, v3a_pkg::WORD_MAX, 0);
    directed(v3a_pkg::FN_DOT, v3a_pkg::WORD_MIN, 1, 32'h8000, v3a_pkg::WORD_MAX, 1, 1, 0);
    directed(v3a_pkg::FN_CROSS, v3a_pkg::WORD_MIN, v3a_pkg::WORD_MAX, v3a_pkg::WORD_MIN,
             v3a_pkg::WORD_MAX, v3a_pkg::WORD_MIN, v3a_pkg::WORD_MAX, 0);
    directed(v3a_pkg::FN_LEN, v3a_pkg::WORD_MIN, v3a_pkg::WORD_MIN, v3a_pkg::WORD_MIN,
             0, 0, 0, 0);
    directed(v3a_pkg::FN_LEN, 32'h00030000, 32'h00040000, 0, 0, 0, 0, 0);
    directed(v3a_pkg::FN_NORM, 0, 0, 0, 0, 0, 0, 0);
    directed(v3a_pkg::FN_NORM, 3, 2, 32'hFFFFFFFE, 0, 0, 0, 0);
    directed(v3a_pkg::FN_NORM, 7, 0, 0, 0, 0, 0, 0);
    directed(v3a_pkg::FN_NORM, v3a_pkg::WORD_MIN, v3a_pkg::WORD_MAX, 1, 0, 0, 0, 0);
    directed(v3a_pkg::FN_DISTSQ, v3a_pkg::WORD_MIN, v3a_pkg::WORD_MIN, v3a_pkg::WORD_MIN,
             v3a_pkg::WORD_MAX, v3a_pkg::WORD_MAX, v3a_pkg::WORD_MAX, 0);
    directed(v3a_pkg::FN_DISTSQ, 32'h00010000, 0, 0, 0, 32'h00010000, 0, 0);
    directed(v3a_pkg::FN_DIST, v3a_pkg::WORD_MAX, v3a_pkg::WORD_MIN, v3a_pkg::WORD_MAX,
             v3a_pkg::WORD_MIN, v3a_pkg::WORD_MAX, v3a_pkg::WORD_MIN, 0);
    directed(v3a_pkg::FN_DIST, 32'h00030000, 0, 0, 0, 32'h00040000, 0, 0);
    directed(4'd12, v3a_pkg::WORD_MAX, 1, 2, 3, 4, 5, 6);
    directed(4'd15, v3a_pkg::WORD_MIN, 1, 2, 3, 4, 5, 6);

    // four phases, each with its own threshold and sender idling
    for (int ph = 0; ph < 4; ph++) begin
      write_min_length(thresholds[ph]);
      idle_pct = phase_pct[ph];
      for (int n = 0; n < 310; n++) begin
        send_item(random_item());
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/v3a_pkg.sv
sv/v3a_lane.sv
sv/v3a_isqrt.sv
sv/v3a_div.sv
sv/vec3_fixed_point_alu_top.sv
verif/v3a_checker.sv
verif/tb_top.sv
